// ----- rtl/core/lscm_pkg.sv -----
// Package for the looping sample channel mixer.
// Holds sizes, the request code enum and the structs used by the core files.
// No dependencies.
package lscm_pkg;

  // Sizes of the stores
  localparam int VOICES    = 4;
  localparam int SOUNDS    = 64;
  localparam int MEM_WORDS = 262144;

  // Field widths of the request and result channels
  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 18;
  localparam int SAMPLE_W = 16;
  localparam int SID_W    = 6;
  localparam int VOICE_W  = 2;
  localparam int LEN_W    = 19;

  // Derived index widths
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int SND_AW = $clog2(SOUNDS);
  localparam int VIX_W  = $clog2(VOICES);

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEM_WR  = 2'd0,
    FUNC_DESC_WR = 2'd1,
    FUNC_START   = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  // One input request
  typedef struct packed {
    func_t                      func;
    logic [ADDR_W-1:0]          mem_address;
    logic signed [SAMPLE_W-1:0] mem_data;
    logic [SID_W-1:0]           sound_id;
    logic [VOICE_W-1:0]         voice;
    logic [LEN_W-1:0]           sound_length;
    logic                       loop_enable;
    logic [ADDR_W-1:0]          loop_point;
  } in_req_t;

  // One mixed result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       any_active;
  } out_res_t;

  // One sound descriptor
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] loop_point;
    logic              loop_on;
  } desc_t;

  // Sample memory port command
  typedef struct packed {
    logic                       we;
    logic                       re;
    logic [MEM_AW-1:0]          addr;
    logic signed [SAMPLE_W-1:0] wdata;
  } mem_cmd_t;

  // Descriptor table port command
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SND_AW-1:0] idx;
    desc_t             wdata;
  } desc_cmd_t;

endpackage

// ----- rtl/core/lscm_if.sv -----
// Valid/ready channel interfaces for the mixer request and result streams.
// Depends on lscm_pkg for field widths.
interface lscm_in_if;
  import lscm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [ADDR_W-1:0]          mem_address;
  logic signed [SAMPLE_W-1:0] mem_data;
  logic [SID_W-1:0]           sound_id;
  logic [VOICE_W-1:0]         voice;
  logic [LEN_W-1:0]           sound_length;
  logic                       loop_enable;
  logic [ADDR_W-1:0]          loop_point;

  modport source (
    output valid, func, mem_address, mem_data, sound_id, voice,
           sound_length, loop_enable, loop_point,
    input  ready
  );
  modport sink (
    input  valid, func, mem_address, mem_data, sound_id, voice,
           sound_length, loop_enable, loop_point,
    output ready
  );
endinterface

interface lscm_out_if;
  import lscm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       any_active;

  modport source (output valid, left_out, right_out, any_active, input ready);
  modport sink (input valid, left_out, right_out, any_active, output ready);
endinterface

// ----- rtl/core/lscm_sample_mem.sv -----
// Single-port sample memory, one write or one read per cycle, registered read.
// Depends on lscm_pkg for sizes and the port command struct.
module lscm_sample_mem (
  input  logic                                         clk,
  input  lscm_pkg::mem_cmd_t                           cmd,
  output logic signed [lscm_pkg::SAMPLE_W-1:0]         rdata_r
);
  import lscm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MEM_WORDS];

  // Write or read the addressed word
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem[cmd.addr];
    end
  end

endmodule

// ----- rtl/core/lscm_desc_table.sv -----
// Sound descriptor table: a memory of descriptors plus per-entry valid bits,
// so an entry never written reads with length zero. Depends on lscm_pkg.
module lscm_desc_table (
  input  logic                clk,
  input  logic                rst_n,
  input  lscm_pkg::desc_cmd_t cmd,
  output lscm_pkg::desc_t     rdata
);
  import lscm_pkg::*;

  desc_t               mem [SOUNDS];
  logic [SOUNDS-1:0]   valid_r;
  desc_t               rd_r;
  logic                rd_valid_r;

  // Store descriptor and read the addressed entry
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.idx] <= cmd.wdata;
    end
    if (cmd.re) begin
      rd_r <= mem[cmd.idx];
    end
  end

  // Track written entries and the valid bit of the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.we) begin
        valid_r[cmd.idx] <= 1'b1;
      end
      if (cmd.re) begin
        rd_valid_r <= valid_r[cmd.idx];
      end
    end
  end

  // Unwritten entries read as missing sounds
  always_comb begin
    rdata = rd_r;
    if (!rd_valid_r) begin
      rdata.length = '0;
    end
  end

endmodule

// ----- rtl/core/lscm_seq.sv -----
// Sequencer of the mixer: decodes requests, holds the voice state and walks
// the voices through one shared memory read and accumulate unit per tick.
// Depends on lscm_pkg.
module lscm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  lscm_pkg::in_req_t    req,
  output logic                 in_ready,
  output lscm_pkg::mem_cmd_t   mem_cmd,
  input  logic signed [lscm_pkg::SAMPLE_W-1:0] mem_rdata,
  output lscm_pkg::desc_cmd_t  desc_cmd,
  input  lscm_pkg::desc_t      desc_rdata,
  output logic                 res_valid,
  input  logic                 res_take,
  output lscm_pkg::out_res_t   res
);
  import lscm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DESC = 5'b00010,
    S_RD   = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Voice state
  logic [VOICES-1:0] vact_r;
  logic [ADDR_W-1:0] vstart_r [VOICES];
  logic [LEN_W-1:0]  vpos_r   [VOICES];
  logic [LEN_W-1:0]  vlen_r   [VOICES];
  logic [ADDR_W-1:0] vloop_r  [VOICES];
  logic [VOICES-1:0] vloop_on_r;

  // Tick and start working registers
  logic [VIX_W-1:0]           vidx_r;
  logic signed [SAMPLE_W-1:0] sum_r;
  logic                       any_r;
  logic [VIX_W-1:0]           sv_idx_r;
  logic                       sv_ok_r;
  logic                       sid_ok_r;

  logic             mem_in_range;
  logic             sid_in_range;
  logic             voice_in_range;
  logic             last_voice;
  logic [LEN_W-1:0] pos_inc;
  logic             start_idle;

  assign start_idle     = (state_r == S_IDLE) && in_fire;
  assign mem_in_range   = 32'(req.mem_address) < MEM_WORDS;
  assign sid_in_range   = 32'(req.sound_id) < SOUNDS;
  assign voice_in_range = 32'(req.voice) < VOICES;
  assign last_voice     = vidx_r == VIX_W'(VOICES - 1);
  assign pos_inc        = vpos_r[vidx_r] + 1'b1;

  assign in_ready  = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res.left_out   = sum_r;
  assign res.right_out  = sum_r;
  assign res.any_active = any_r;

  // Drive the sample memory port
  always_comb begin
    mem_cmd = '0;
    if (start_idle && req.func == FUNC_MEM_WR && mem_in_range) begin
      mem_cmd.we    = 1'b1;
      mem_cmd.addr  = req.mem_address[MEM_AW-1:0];
      mem_cmd.wdata = req.mem_data;
    end else if (state_r == S_RD) begin
      mem_cmd.re   = 1'b1;
      mem_cmd.addr = MEM_AW'(vstart_r[vidx_r] + vpos_r[vidx_r][ADDR_W-1:0]);
    end
  end

  // Drive the descriptor table port
  always_comb begin
    desc_cmd = '0;
    desc_cmd.idx = req.sound_id[SND_AW-1:0];
    desc_cmd.wdata.start      = req.mem_address;
    desc_cmd.wdata.length     = req.sound_length;
    desc_cmd.wdata.loop_point = req.loop_point;
    desc_cmd.wdata.loop_on    = req.loop_enable;
    if (start_idle && req.func == FUNC_DESC_WR && sid_in_range) begin
      desc_cmd.we = 1'b1;
    end
    if (start_idle && req.func == FUNC_START) begin
      desc_cmd.re = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && req.func == FUNC_START) begin
          state_nxt = S_DESC;
        end else if (in_fire && req.func == FUNC_TICK) begin
          state_nxt = S_RD;
        end
      end
      S_DESC: state_nxt = S_IDLE;
      S_RD:   state_nxt = S_ACC;
      S_ACC:  state_nxt = last_voice ? S_DONE : S_RD;
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch request context, walk the voice index and accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r   <= '0;
      sum_r    <= '0;
      any_r    <= 1'b0;
      sv_idx_r <= '0;
      sv_ok_r  <= 1'b0;
      sid_ok_r <= 1'b0;
    end else begin
      if (start_idle) begin
        sv_idx_r <= req.voice[VIX_W-1:0];
        sv_ok_r  <= voice_in_range;
        sid_ok_r <= sid_in_range;
        vidx_r   <= '0;
        sum_r    <= '0;
        any_r    <= |vact_r;
      end
      if (state_r == S_ACC) begin
        vidx_r <= vidx_r + 1'b1;
        if (vact_r[vidx_r]) begin
          sum_r <= sum_r + mem_rdata;
        end
      end
    end
  end

  // Update voice state: load or silence on start, advance or loop or stop on tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vact_r     <= '0;
      vloop_on_r <= '0;
      for (int i = 0; i < VOICES; i++) begin
        vstart_r[i] <= '0;
        vpos_r[i]   <= '0;
        vlen_r[i]   <= '0;
        vloop_r[i]  <= '0;
      end
    end else begin
      if (state_r == S_DESC && sv_ok_r) begin
        if (!sid_ok_r || desc_rdata.length == '0) begin
          vact_r[sv_idx_r] <= 1'b0;
        end else begin
          vact_r[sv_idx_r]     <= 1'b1;
          vstart_r[sv_idx_r]   <= desc_rdata.start;
          vpos_r[sv_idx_r]     <= '0;
          vlen_r[sv_idx_r]     <= desc_rdata.length;
          vloop_r[sv_idx_r]    <= desc_rdata.loop_point;
          vloop_on_r[sv_idx_r] <= desc_rdata.loop_on;
        end
      end
      if (state_r == S_ACC && vact_r[vidx_r]) begin
        if (pos_inc >= vlen_r[vidx_r]) begin
          if (vloop_on_r[vidx_r]) begin
            vpos_r[vidx_r] <= LEN_W'(vloop_r[vidx_r]);
          end else begin
            vpos_r[vidx_r] <= pos_inc;
            vact_r[vidx_r] <= 1'b0;
          end
        end else begin
          vpos_r[vidx_r] <= pos_inc;
        end
      end
    end
  end

endmodule

// ----- rtl/core/looping_sample_channel_mixer.sv -----
// Top level of the looping sample channel mixer.
// Depends on lscm_pkg, lscm_if, lscm_sample_mem, lscm_desc_table and lscm_seq.
//
// Requests are taken one at a time. A memory write or descriptor write is done
// as it is taken, a voice start adds one descriptor table read. During an
// output tick each voice in turn gets a read state and an accumulate state
// on the single sample memory port, and the finished sum moves into the output
// register once that is empty or being drained, after which the next request
// is taken at once even while the result waits on the sink.
// Unwritten descriptors read as missing sounds; sample words never written
// read as undefined values.
module looping_sample_channel_mixer (
  input logic        clk,
  input logic        rst_n,
  lscm_in_if.sink    in_ch,
  lscm_out_if.source out_ch
);
  import lscm_pkg::*;

  in_req_t   req;
  mem_cmd_t  mem_cmd;
  desc_cmd_t desc_cmd;
  desc_t     desc_rdata;
  out_res_t  res;
  out_res_t  out_r;
  logic      out_valid_r;
  logic      res_valid;
  logic      res_take;
  logic      seq_ready;
  logic      in_fire;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  // Gather the request payload
  always_comb begin
    req.func         = func_t'(in_ch.func);
    req.mem_address  = in_ch.mem_address;
    req.mem_data     = in_ch.mem_data;
    req.sound_id     = in_ch.sound_id;
    req.voice        = in_ch.voice;
    req.sound_length = in_ch.sound_length;
    req.loop_enable  = in_ch.loop_enable;
    req.loop_point   = in_ch.loop_point;
  end

  assign in_ch.ready = seq_ready;
  assign in_fire     = in_ch.valid && seq_ready;

  lscm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .req        (req),
    .in_ready   (seq_ready),
    .mem_cmd    (mem_cmd),
    .mem_rdata  (mem_rdata),
    .desc_cmd   (desc_cmd),
    .desc_rdata (desc_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  lscm_sample_mem u_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rdata_r (mem_rdata)
  );

  lscm_desc_table u_desc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (desc_cmd),
    .rdata (desc_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_out   = out_r.left_out;
  assign out_ch.right_out  = out_r.right_out;
  assign out_ch.any_active = out_r.any_active;

endmodule

// ----- rtl/core/lscm_checker.sv -----
// Port-level checks for the looping sample channel mixer, bound to the top.
// Depends on lscm_pkg for widths and request codes.
module lscm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [lscm_pkg::FUNC_W-1:0]          in_func,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [lscm_pkg::SAMPLE_W-1:0] left_out,
  input logic signed [lscm_pkg::SAMPLE_W-1:0] right_out,
  input logic                                 any_active
);
  import lscm_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_out))
    else $error("stalled result changed");

  // Keep both stereo outputs equal
  a_stereo_eq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> left_out == right_out)
    else $error("left and right differ");

  // Give silence when no voice played
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !any_active |-> left_out == '0)
    else $error("nonzero sum with no active voice");

  // Drop ready while a tick is being mixed
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_TICK |=> !in_ready)
    else $error("request taken during a tick");

endmodule

bind looping_sample_channel_mixer lscm_checker u_lscm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .left_out   (out_ch.left_out),
  .right_out  (out_ch.right_out),
  .any_active (out_ch.any_active)
);

// ----- tb/tb_looping_sample_channel_mixer.sv -----
// Self-checking testbench for looping_sample_channel_mixer: bursty request driver,
// stalling result sink, and an in-order predictor of the mixed ticks.
// Depends on lscm_pkg, lscm_if and the mixer RTL.
module tb_looping_sample_channel_mixer;
  import lscm_pkg::*;

  localparam int PLAN        = 0;      // state copy used while building requests
  localparam int LIVE        = 1;      // state copy advanced on accepted requests
  localparam int RANDOM_REQS = 800;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 30;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic    drain_first;  // wait until every mixed tick has arrived
    in_req_t req;
  } send_item_t;

  logic clk;
  logic rst_n;

  lscm_in_if  in_ch ();
  lscm_out_if out_ch ();

  looping_sample_channel_mixer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mixer state, one copy per use
  logic [SAMPLE_W-1:0] sample_mem [int];
  bit [ADDR_W-1:0]     snd_start   [2][SOUNDS];
  bit [LEN_W-1:0]      snd_len     [2][SOUNDS];
  bit [ADDR_W-1:0]     snd_loop    [2][SOUNDS];
  bit                  snd_loop_on [2][SOUNDS];
  bit                  vc_on       [2][VOICES];
  bit [ADDR_W-1:0]     vc_start    [2][VOICES];
  bit [LEN_W-1:0]      vc_pos      [2][VOICES];
  bit [LEN_W-1:0]      vc_len      [2][VOICES];
  bit [ADDR_W-1:0]     vc_loop     [2][VOICES];
  bit                  vc_loop_on  [2][VOICES];

  send_item_t requests_to_send [$];
  out_res_t   mixes_due [$];
  bit         drain_next;
  int         queued_total;

  // Driver, monitor and sink bookkeeping
  in_req_t  offered;
  out_res_t mix_got;
  out_res_t mix_want;
  int       sent_count;
  int       results_seen;
  int       playing_seen;
  int       mismatches;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  bit       long_hold_done;
  bit       calm;
  int       cycle_count;

  function automatic int word_key(input int cp, input logic [ADDR_W-1:0] a);
    return cp * MEM_WORDS + int'(a);
  endfunction

  // Apply one request to a state copy; return 1 with the mix for an output tick
  function automatic bit mix_request(input int cp, input in_req_t r, output out_res_t res);
    logic [SAMPLE_W-1:0] sum;
    logic [ADDR_W-1:0]   a;
    bit                  any;
    sum = '0;
    any = 1'b0;
    res = '0;
    case (r.func)
      FUNC_MEM_WR: begin
        sample_mem[word_key(cp, r.mem_address)] = r.mem_data;
        return 1'b0;
      end
      FUNC_DESC_WR: begin
        snd_start[cp][r.sound_id]   = r.mem_address;
        snd_len[cp][r.sound_id]     = r.sound_length;
        snd_loop[cp][r.sound_id]    = r.loop_point;
        snd_loop_on[cp][r.sound_id] = r.loop_enable;
        return 1'b0;
      end
      FUNC_START: begin
        // A missing sound silences the voice
        if (snd_len[cp][r.sound_id] == '0) begin
          vc_on[cp][r.voice] = 1'b0;
        end else begin
          vc_on[cp][r.voice]      = 1'b1;
          vc_start[cp][r.voice]   = snd_start[cp][r.sound_id];
          vc_pos[cp][r.voice]     = '0;
          vc_len[cp][r.voice]     = snd_len[cp][r.sound_id];
          vc_loop[cp][r.voice]    = snd_loop[cp][r.sound_id];
          vc_loop_on[cp][r.voice] = snd_loop_on[cp][r.sound_id];
        end
        return 1'b0;
      end
      default: ;
    endcase
    for (int v = 0; v < VOICES; v++) any |= vc_on[cp][v];
    // Sum every playing voice, then advance it and loop or stop at its end
    for (int v = 0; v < VOICES; v++) begin
      if (vc_on[cp][v]) begin
        a = ADDR_W'(vc_start[cp][v] + vc_pos[cp][v]);
        sum = sum + (sample_mem.exists(word_key(cp, a)) ? sample_mem[word_key(cp, a)] : '0);
        vc_pos[cp][v] = LEN_W'(vc_pos[cp][v] + 1'b1);
        if (vc_pos[cp][v] >= vc_len[cp][v]) begin
          if (vc_loop_on[cp][v]) vc_pos[cp][v] = LEN_W'(vc_loop[cp][v]);
          else vc_on[cp][v] = 1'b0;
        end
      end
    end
    res.left_out   = sum;
    res.right_out  = sum;
    res.any_active = any;
    return 1'b1;
  endfunction

  // Every field random; callers pin the fields their request uses
  function automatic in_req_t random_request();
    in_req_t r;
    r.func         = func_t'(FUNC_W'($urandom_range(0, 3)));
    r.mem_address  = ADDR_W'($urandom());
    r.mem_data     = SAMPLE_W'($urandom());
    r.sound_id     = SID_W'($urandom());
    r.voice        = VOICE_W'($urandom());
    r.sound_length = LEN_W'($urandom());
    r.loop_enable  = 1'($urandom());
    r.loop_point   = ADDR_W'($urandom());
    return r;
  endfunction

  function automatic void enqueue(input in_req_t r);
    out_res_t   scratch;
    send_item_t item;
    void'(mix_request(PLAN, r, scratch));
    item.drain_first = drain_next;
    item.req = r;
    requests_to_send.push_back(item);
    drain_next = 1'b0;
    queued_total++;
  endfunction

  // Before a tick, write any word a playing voice is about to read for the first time
  function automatic void queue_request(input in_req_t r);
    in_req_t         fill;
    logic [ADDR_W-1:0] a;
    if (r.func == FUNC_TICK) begin
      for (int v = 0; v < VOICES; v++) begin
        a = ADDR_W'(vc_start[PLAN][v] + vc_pos[PLAN][v]);
        if (vc_on[PLAN][v] && !sample_mem.exists(word_key(PLAN, a))) begin
          fill = random_request();
          fill.func = FUNC_MEM_WR;
          fill.mem_address = a;
          enqueue(fill);
        end
      end
    end
    enqueue(r);
  endfunction

  function automatic void mem_word(input logic [ADDR_W-1:0] a, input logic [SAMPLE_W-1:0] d);
    in_req_t r;
    r = random_request();
    r.func = FUNC_MEM_WR;
    r.mem_address = a;
    r.mem_data = d;
    queue_request(r);
  endfunction

  function automatic void set_sound(input logic [SID_W-1:0] sid, input logic [ADDR_W-1:0] start,
                                    input logic [LEN_W-1:0] len, input logic lp_on,
                                    input logic [ADDR_W-1:0] lp);
    in_req_t r;
    r = random_request();
    r.func = FUNC_DESC_WR;
    r.sound_id = sid;
    r.mem_address = start;
    r.sound_length = len;
    r.loop_enable = lp_on;
    r.loop_point = lp;
    queue_request(r);
  endfunction

  function automatic void start_voice(input logic [VOICE_W-1:0] v, input logic [SID_W-1:0] sid);
    in_req_t r;
    r = random_request();
    r.func = FUNC_START;
    r.voice = v;
    r.sound_id = sid;
    queue_request(r);
  endfunction

  function automatic void tick();
    in_req_t r;
    r = random_request();
    r.func = FUNC_TICK;
    queue_request(r);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Build the request list, release reset, wait for the last mix, report
  initial begin
    int                  pick;
    int                  len;
    int                  n;
    logic [SID_W-1:0]    sid;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   lp;
    int                  next_drain;
    rst_n <= 1'b0;

    // Directed: silence, missing sounds, extreme words, wrap, far loop, long sound
    tick();
    start_voice(2'd0, 6'd5);
    tick();
    mem_word(18'd0, 16'h7FFF);
    mem_word(18'd1, 16'h8000);
    mem_word(18'd2, 16'hFFFF);
    mem_word(18'd262142, 16'h7FFF);
    mem_word(18'd262143, 16'h0001);
    set_sound(6'd0, 18'd0, 19'd3, 1'b0, 18'd0);
    set_sound(6'd63, 18'd262142, 19'd4, 1'b1, 18'd2);
    set_sound(6'd1, 18'd0, 19'd2, 1'b1, 18'd262143);
    set_sound(6'd2, 18'd100, 19'd524287, 1'b0, 18'd262143);
    set_sound(6'd3, 18'd0, 19'd0, 1'b1, 18'd5);
    start_voice(2'd0, 6'd0);
    start_voice(2'd1, 6'd63);
    start_voice(2'd2, 6'd1);
    start_voice(2'd3, 6'd2);
    repeat (4) tick();
    start_voice(2'd3, 6'd3);
    tick();
    start_voice(2'd2, 6'd63);
    tick();

    // Random: mostly load-play sequences, some noise, silencing and tick runs
    next_drain = queued_total + 300;
    while (queued_total < RANDOM_REQS + 25) begin
      if (queued_total >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 300;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        sid  = SID_W'($urandom());
        base = ADDR_W'($urandom());
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          if ($urandom_range(0, 3) != 0) mem_word(ADDR_W'(base + i), SAMPLE_W'($urandom()));
        lp = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom())
                                         : ADDR_W'($urandom_range(0, len + 1));
        set_sound(sid, base, LEN_W'(len), 1'($urandom()), lp);
        start_voice(VOICE_W'($urandom()), sid);
        n = $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) start_voice(VOICE_W'($urandom()), SID_W'($urandom()));
          tick();
        end
      end else if (pick == 6) begin
        queue_request(random_request());
      end else if (pick == 7) begin
        start_voice(VOICE_W'($urandom()), SID_W'($urandom()));
      end else begin
        repeat ($urandom_range(3, 10)) tick();
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_to_send.size() != 0 || in_ch.valid || mixes_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests; checked %0d mixed ticks, %0d with a voice playing.",
             sent_count, results_seen, playing_seen);
    $display("Mismatched or unexpected ticks: %0d", mismatches);
    if (mismatches == 0) $display("looping_sample_channel_mixer test passed");
    else $display("looping_sample_channel_mixer test failed");
    $finish;
  end

  // Quiet stretch: no new gaps on either side
  always_comb calm = (sent_count >= 450) && (sent_count < 600);

  // Driver: predict accepted requests, offer the next one in bursts
  always @(posedge clk) begin
    out_res_t   res;
    send_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= '0;
      in_ch.mem_address <= '0;
      in_ch.mem_data <= '0;
      in_ch.sound_id <= '0;
      in_ch.voice <= '0;
      in_ch.sound_length <= '0;
      in_ch.loop_enable <= 1'b0;
      in_ch.loop_point <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (mix_request(LIVE, offered, res)) mixes_due.push_back(res);
        sent_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (requests_to_send.size() != 0 &&
                     !(requests_to_send[0].drain_first && mixes_due.size() != 0)) begin
          item = requests_to_send.pop_front();
          offered = item.req;
          in_ch.valid <= 1'b1;
          in_ch.func <= offered.func;
          in_ch.mem_address <= offered.mem_address;
          in_ch.mem_data <= offered.mem_data;
          in_ch.sound_id <= offered.sound_id;
          in_ch.voice <= offered.voice;
          in_ch.sound_length <= offered.sound_length;
          in_ch.loop_enable <= offered.loop_enable;
          in_ch.loop_point <= offered.loop_point;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sink: short random stalls, one long hold once the mixes are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (!long_hold_done && results_seen >= 100) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted mix with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mix_got.left_out   = out_ch.left_out;
      mix_got.right_out  = out_ch.right_out;
      mix_got.any_active = out_ch.any_active;
      results_seen++;
      if (out_ch.any_active === 1'b1) playing_seen++;
      if (mixes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected mix: left %0d right %0d active %0b",
                   mix_got.left_out, mix_got.right_out, mix_got.any_active);
      end else begin
        mix_want = mixes_due.pop_front();
        if (mix_got.left_out !== mix_want.left_out ||
            mix_got.right_out !== mix_want.right_out ||
            mix_got.any_active !== mix_want.any_active) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mix %0d: want left %0d right %0d active %0b, got %0d %0d %0b",
                     results_seen, mix_want.left_out, mix_want.right_out,
                     mix_want.any_active, mix_got.left_out, mix_got.right_out,
                     mix_got.any_active);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d mixes due", cycle_count, mixes_due.size());
      $display("looping_sample_channel_mixer test failed");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/core/lscm_pkg.sv
rtl/core/lscm_if.sv
rtl/core/lscm_sample_mem.sv
rtl/core/lscm_desc_table.sv
rtl/core/lscm_seq.sv
rtl/core/looping_sample_channel_mixer.sv
rtl/core/lscm_checker.sv
tb/tb_looping_sample_channel_mixer.sv
